[design/ttlrc_pkg.sv]
// Shared types and constants for the verdict cache with a time-to-live.
package ttlrc_pkg;

    localparam int ENTRIES = 128;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int SLOT_W  = 7;
    localparam int WORD_W  = 64;

    localparam logic [WORD_W-1:0] TTL_RESET = 64'd300000000000;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_RECORD = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] key_hi;
        logic [WORD_W-1:0] key_lo;
        logic              family;
        logic [WORD_W-1:0] stamp;
        logic              verdict;
    } entry_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic last_addr;
        logic pipe_idle;
    } sts_t;

endpackage

[design/ttlrc_ctrl.sv]
// Controller state machine that sequences the table scan for one item.
module ttlrc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ttlrc_pkg::sts_t   sts,
    output ttlrc_pkg::cmd_t   cmd,
    output logic              busy
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (sts.last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (sts.pipe_idle)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    a_load_then_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_SCAN))
        else $error("A loaded item did not enter the scan.");

    a_commit_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> !busy)
        else $error("The controller stayed busy after the commit.");

endmodule

[design/ttlrc_dp.sv]
// Datapath: entry memory, valid bits, scan pipeline, match and oldest-entry search.
module ttlrc_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ttlrc_pkg::cmd_t                  cmd,
    output ttlrc_pkg::sts_t                  sts,
    input  logic                             ttl_ns_we,
    input  logic [ttlrc_pkg::WORD_W-1:0]     ttl_ns,
    input  logic                             op,
    input  logic [ttlrc_pkg::WORD_W-1:0]     addr_hi,
    input  logic [ttlrc_pkg::WORD_W-1:0]     addr_lo,
    input  logic                             is_v6,
    input  logic [ttlrc_pkg::WORD_W-1:0]     now_ns,
    input  logic                             verdict_in,
    output logic                             done,
    output logic                             hit,
    output logic                             verdict_out,
    output logic [ttlrc_pkg::SLOT_W-1:0]     slot
);

    localparam int IW = ttlrc_pkg::IDX_W;
    localparam int WW = ttlrc_pkg::WORD_W;
    localparam int SW = ttlrc_pkg::SLOT_W;

    logic [WW-1:0] ttl_reg;

    logic          op_reg;
    logic [WW-1:0] key_hi_reg;
    logic [WW-1:0] key_lo_reg;
    logic          fam_reg;
    logic [WW-1:0] now_reg;
    logic          vin_reg;

    logic [IW-1:0]              rd_addr_reg;
    logic [ttlrc_pkg::ENTRIES-1:0] valid_reg;
    ttlrc_pkg::entry_t          mem [ttlrc_pkg::ENTRIES];
    ttlrc_pkg::entry_t          rd_data_reg;
    logic                       rd_valid_reg;

    logic          s1_vld_reg;
    logic [IW-1:0] s1_idx_reg;

    logic          s2_vld_reg;
    logic [IW-1:0] s2_idx_reg;
    logic          s2_eq_reg;
    logic [WW-1:0] s2_age_reg;
    logic [WW-1:0] s2_stamp_reg;
    logic          s2_verdict_reg;

    logic          found_reg;
    logic [IW-1:0] res_idx_reg;
    logic          res_verdict_reg;
    logic [IW-1:0] pick_idx_reg;
    logic [WW-1:0] min_stamp_reg;

    logic          done_reg;
    logic          hit_reg;
    logic          verdict_out_reg;
    logic [SW-1:0] slot_reg;

    logic          s1_eq;
    logic          take;
    logic          older;
    logic [IW-1:0] wr_idx;
    logic [SW+IW-1:0] wr_slot_wide;
    logic [SW+IW-1:0] res_slot_wide;
    ttlrc_pkg::entry_t wr_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg <= ttlrc_pkg::TTL_RESET;
        end
        else if (ttl_ns_we)
        begin
            ttl_reg <= ttl_ns;
        end
    end

    // Item capture; an IPv4 key keeps only the low 32 address bits.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op;
            fam_reg    <= is_v6;
            key_hi_reg <= is_v6 ? addr_hi : '0;
            key_lo_reg <= is_v6 ? addr_lo : {32'd0, addr_lo[31:0]};
            now_reg    <= now_ns;
            vin_reg    <= verdict_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg <= '0;
        end
        else if (cmd.load)
        begin
            rd_addr_reg <= '0;
        end
        else if (cmd.rd_en)
        begin
            rd_addr_reg <= rd_addr_reg + 1'b1;
        end
    end

    assign wr_idx = found_reg ? res_idx_reg : pick_idx_reg;

    always_comb
    begin
        wr_entry.key_hi  = key_hi_reg;
        wr_entry.key_lo  = key_lo_reg;
        wr_entry.family  = fam_reg;
        wr_entry.stamp   = now_reg;
        wr_entry.verdict = vin_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && (op_reg == ttlrc_pkg::OP_RECORD))
        begin
            mem[wr_idx] <= wr_entry;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit && (op_reg == ttlrc_pkg::OP_RECORD))
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr_reg];
            end
        end
    end

    assign s1_eq = rd_valid_reg && (rd_data_reg.family == fam_reg) &&
                   (rd_data_reg.key_hi == key_hi_reg) && (rd_data_reg.key_lo == key_lo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd.rd_en;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // An empty entry reads as stamp zero so that it is the oldest.
    always_ff @(posedge clk)
    begin
        s1_idx_reg     <= rd_addr_reg;
        s2_idx_reg     <= s1_idx_reg;
        s2_eq_reg      <= s1_eq;
        s2_age_reg     <= now_reg - rd_data_reg.stamp;
        s2_stamp_reg   <= rd_valid_reg ? rd_data_reg.stamp : '0;
        s2_verdict_reg <= rd_data_reg.verdict;
    end

    assign take  = s2_eq_reg && ((op_reg == ttlrc_pkg::OP_RECORD) || (s2_age_reg < ttl_reg));
    assign older = (op_reg == ttlrc_pkg::OP_RECORD) && (s2_stamp_reg < min_stamp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            found_reg <= 1'b0;
        end
        else if (s2_vld_reg && !found_reg && take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pick_idx_reg  <= '0;
            min_stamp_reg <= '1;
        end
        else if (s2_vld_reg && !found_reg)
        begin
            if (take)
            begin
                res_idx_reg     <= s2_idx_reg;
                res_verdict_reg <= s2_verdict_reg;
            end
            else if (older)
            begin
                pick_idx_reg  <= s2_idx_reg;
                min_stamp_reg <= s2_stamp_reg;
            end
        end
    end

    assign wr_slot_wide  = {{SW{1'b0}}, wr_idx};
    assign res_slot_wide = {{SW{1'b0}}, res_idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            verdict_out_reg <= 1'b0;
            slot_reg        <= '0;
        end
        else
        begin
            done_reg <= cmd.commit;
            if (cmd.commit)
            begin
                if (op_reg == ttlrc_pkg::OP_RECORD)
                begin
                    hit_reg         <= 1'b0;
                    verdict_out_reg <= 1'b0;
                    slot_reg        <= wr_slot_wide[SW-1:0];
                end
                else
                begin
                    hit_reg         <= found_reg;
                    verdict_out_reg <= found_reg && res_verdict_reg;
                    slot_reg        <= found_reg ? res_slot_wide[SW-1:0] : '0;
                end
            end
        end
    end

    assign sts.last_addr = cmd.rd_en && (rd_addr_reg == IW'(ttlrc_pkg::ENTRIES - 1));
    assign sts.pipe_idle = !s1_vld_reg && !s2_vld_reg;

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign verdict_out = verdict_out_reg;
    assign slot        = slot_reg;

    a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(cmd.commit))
        else $error("A result appeared without a commit.");

    a_commit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!s1_vld_reg && !s2_vld_reg))
        else $error("Commit while the scan pipeline still held entries.");

    a_hit_only_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && hit_reg) |-> (op_reg == ttlrc_pkg::OP_LOOKUP))
        else $error("A record reported a hit.");

    a_record_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (op_reg == ttlrc_pkg::OP_RECORD)) |=> valid_reg[$past(wr_idx)])
        else $error("A recorded entry was not marked valid.");

endmodule

[design/ttl_result_cache_oldest_replace.sv]
// Top level of the verdict cache with a time-to-live and oldest-entry replacement.
// After the accepting edge the item is loaded, every entry is scanned, the pipeline drains and the commit sets done.
// The scan reads one entry a cycle; no new item is taken until the current one is committed.
// The entry memory is read one entry at a time, so busy is high throughout the item.
// Reset empties the table through its valid bits and loads the lifetime register with 300 s.
// Results are shown for one cycle on done; the receiver cannot stall them.
module ttl_result_cache_oldest_replace (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             ttl_ns_we,
    input  logic [ttlrc_pkg::WORD_W-1:0]     ttl_ns,
    input  logic                             op,
    input  logic [ttlrc_pkg::WORD_W-1:0]     addr_hi,
    input  logic [ttlrc_pkg::WORD_W-1:0]     addr_lo,
    input  logic                             is_v6,
    input  logic [ttlrc_pkg::WORD_W-1:0]     now_ns,
    input  logic                             verdict_in,
    output logic                             done,
    output logic                             hit,
    output logic                             verdict_out,
    output logic [ttlrc_pkg::SLOT_W-1:0]     slot
);

    ttlrc_pkg::cmd_t cmd;
    ttlrc_pkg::sts_t sts;

    ttlrc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    ttlrc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .ttl_ns_we   (ttl_ns_we),
        .ttl_ns      (ttl_ns),
        .op          (op),
        .addr_hi     (addr_hi),
        .addr_lo     (addr_lo),
        .is_v6       (is_v6),
        .now_ns      (now_ns),
        .verdict_in  (verdict_in),
        .done        (done),
        .hit         (hit),
        .verdict_out (verdict_out),
        .slot        (slot)
    );

endmodule

[dv/tb.sv]
// Self-checking testbench for the verdict cache with a time-to-live and oldest-entry replacement.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_POOL    = 170;
    localparam int CYCLE_LIMIT = 1200000;

    typedef struct {
        logic                         op;
        logic [ttlrc_pkg::WORD_W-1:0] addr_hi;
        logic [ttlrc_pkg::WORD_W-1:0] addr_lo;
        logic                         is_v6;
        logic [ttlrc_pkg::WORD_W-1:0] now_ns;
        logic                         verdict_in;
    } cache_item_t;

    typedef struct {
        logic                         hit;
        logic                         verdict;
        logic [ttlrc_pkg::SLOT_W-1:0] slot;
    } cache_answer_t;

    class cache_scoreboard;
        logic [ttlrc_pkg::WORD_W-1:0] ttl;
        bit                           valid [ttlrc_pkg::ENTRIES];
        logic [ttlrc_pkg::WORD_W-1:0] key_hi [ttlrc_pkg::ENTRIES];
        logic [ttlrc_pkg::WORD_W-1:0] key_lo [ttlrc_pkg::ENTRIES];
        bit                           family [ttlrc_pkg::ENTRIES];
        logic [ttlrc_pkg::WORD_W-1:0] stamp [ttlrc_pkg::ENTRIES];
        bit                           verdict [ttlrc_pkg::ENTRIES];
        cache_answer_t                pending_answers [$];
        int                           errors;
        int                           lookups;
        int                           hits;
        int                           records;

        function new();
            ttl = ttlrc_pkg::TTL_RESET;
            for (int i = 0; i < ttlrc_pkg::ENTRIES; i++)
            begin
                valid[i]   = 1'b0;
                key_hi[i]  = '0;
                key_lo[i]  = '0;
                family[i]  = 1'b0;
                stamp[i]   = '0;
                verdict[i] = 1'b0;
            end
            errors  = 0;
            lookups = 0;
            hits    = 0;
            records = 0;
        endfunction

        function void set_ttl(logic [ttlrc_pkg::WORD_W-1:0] value);
            ttl = value;
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction

        function bit same_key(int i, logic [ttlrc_pkg::WORD_W-1:0] hi,
                              logic [ttlrc_pkg::WORD_W-1:0] lo, logic fam);
            return valid[i] && family[i] == fam && key_hi[i] == hi && key_lo[i] == lo;
        endfunction

        function void note_item(cache_item_t it);
            cache_answer_t                ans;
            logic [ttlrc_pkg::WORD_W-1:0] hi;
            logic [ttlrc_pkg::WORD_W-1:0] lo;
            logic [ttlrc_pkg::WORD_W-1:0] age;
            int                           pick;
            bit                           found;
            hi          = it.is_v6 ? it.addr_hi : '0;
            lo          = it.is_v6 ? it.addr_lo : {32'd0, it.addr_lo[31:0]};
            ans.hit     = 1'b0;
            ans.verdict = 1'b0;
            ans.slot    = '0;
            pick        = 0;
            found       = 1'b0;
            if (it.op == ttlrc_pkg::OP_LOOKUP)
            begin
                lookups++;
                for (int i = 0; i < ttlrc_pkg::ENTRIES && !found; i++)
                begin
                    age = it.now_ns - stamp[i];
                    if (same_key(i, hi, lo, it.is_v6) && age < ttl)
                    begin
                        found       = 1'b1;
                        ans.hit     = 1'b1;
                        ans.verdict = verdict[i];
                        ans.slot    = ttlrc_pkg::SLOT_W'(i);
                    end
                end
                if (found)
                    hits++;
            end
            else
            begin
                records++;
                for (int i = 0; i < ttlrc_pkg::ENTRIES && !found; i++)
                begin
                    if (same_key(i, hi, lo, it.is_v6))
                    begin
                        pick  = i;
                        found = 1'b1;
                    end
                    else if (stamp[i] < stamp[pick])
                        pick = i;
                end
                valid[pick]   = 1'b1;
                key_hi[pick]  = hi;
                key_lo[pick]  = lo;
                family[pick]  = it.is_v6;
                stamp[pick]   = it.now_ns;
                verdict[pick] = it.verdict_in;
                ans.slot      = ttlrc_pkg::SLOT_W'(pick);
            end
            pending_answers.push_back(ans);
        endfunction

        function void check_result(logic hit_q, logic verdict_q,
                                   logic [ttlrc_pkg::SLOT_W-1:0] slot_q);
            cache_answer_t want;
            if (pending_answers.size() == 0)
            begin
                $error("Result with no item outstanding: hit %0d, verdict_out %0d, slot %0d.",
                       hit_q, verdict_q, slot_q);
                errors++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (hit_q !== want.hit)
                begin
                    $error("hit: expected %0d, actual %0d", want.hit, hit_q);
                    errors++;
                end
                if (verdict_q !== want.verdict)
                begin
                    $error("verdict_out: expected %0d, actual %0d", want.verdict, verdict_q);
                    errors++;
                end
                if (slot_q !== want.slot)
                begin
                    $error("slot: expected %0d, actual %0d", want.slot, slot_q);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic                         ttl_ns_we;
    logic [ttlrc_pkg::WORD_W-1:0] ttl_ns;
    logic                         op;
    logic [ttlrc_pkg::WORD_W-1:0] addr_hi;
    logic [ttlrc_pkg::WORD_W-1:0] addr_lo;
    logic                         is_v6;
    logic [ttlrc_pkg::WORD_W-1:0] now_ns;
    logic                         verdict_in;
    logic                         done;
    logic                         hit;
    logic                         verdict_out;
    logic [ttlrc_pkg::SLOT_W-1:0] slot;

    cache_scoreboard              sb;
    int unsigned                  cycle_count = 0;
    bit                           idle_on;
    logic [ttlrc_pkg::WORD_W-1:0] clock_now;
    logic [ttlrc_pkg::WORD_W-1:0] pool_hi [KEY_POOL];
    logic [ttlrc_pkg::WORD_W-1:0] pool_lo [KEY_POOL];
    logic                         pool_v6 [KEY_POOL];

    ttl_result_cache_oldest_replace uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .ttl_ns_we   (ttl_ns_we),
        .ttl_ns      (ttl_ns),
        .op          (op),
        .addr_hi     (addr_hi),
        .addr_lo     (addr_lo),
        .is_v6       (is_v6),
        .now_ns      (now_ns),
        .verdict_in  (verdict_in),
        .done        (done),
        .hit         (hit),
        .verdict_out (verdict_out),
        .slot        (slot)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_result(hit, verdict_out, slot);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with results still due.", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_item(input cache_item_t it);
        bit taken;
        int gap;
        taken = 1'b0;
        while (!taken)
        begin
            if (idle_on && $urandom_range(0, 99) < 7)
            begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 140) : 1;
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            start      <= 1'b1;
            op         <= it.op;
            addr_hi    <= it.addr_hi;
            addr_lo    <= it.addr_lo;
            is_v6      <= it.is_v6;
            now_ns     <= it.now_ns;
            verdict_in <= it.verdict_in;
            @(posedge clk);
            taken = !busy;
        end
        sb.note_item(it);
    endtask

    task automatic send_fields(input logic f_op, input logic [ttlrc_pkg::WORD_W-1:0] f_hi,
                               input logic [ttlrc_pkg::WORD_W-1:0] f_lo, input logic f_v6,
                               input logic [ttlrc_pkg::WORD_W-1:0] f_now, input logic f_vin);
        cache_item_t it;
        it.op         = f_op;
        it.addr_hi    = f_hi;
        it.addr_lo    = f_lo;
        it.is_v6      = f_v6;
        it.now_ns     = f_now;
        it.verdict_in = f_vin;
        send_item(it);
    endtask

    task automatic write_ttl(input logic [ttlrc_pkg::WORD_W-1:0] value);
        start <= 1'b0;
        while (sb.pending() != 0 || busy)
            @(posedge clk);
        ttl_ns_we <= 1'b1;
        ttl_ns    <= value;
        @(posedge clk);
        sb.set_ttl(value);
        ttl_ns_we <= 1'b0;
    endtask

    function automatic cache_item_t make_item(int rec_pct, int step_max);
        cache_item_t it;
        int          k;
        it.op = ($urandom_range(0, 99) < rec_pct) ? ttlrc_pkg::OP_RECORD : ttlrc_pkg::OP_LOOKUP;
        if ($urandom_range(0, 99) < 10)
        begin
            it.addr_hi = {$urandom, $urandom};
            it.addr_lo = {$urandom, $urandom};
            it.is_v6   = 1'($urandom_range(0, 1));
        end
        else
        begin
            k          = $urandom_range(0, KEY_POOL - 1);
            it.addr_hi = pool_hi[k];
            it.addr_lo = pool_lo[k];
            it.is_v6   = pool_v6[k];
            if (!pool_v6[k])
            begin
                it.addr_hi        = {$urandom, $urandom};
                it.addr_lo[63:32] = $urandom;
            end
        end
        if ($urandom_range(0, 99) < 3)
            it.now_ns = {$urandom, $urandom};
        else
        begin
            clock_now = clock_now + $urandom_range(0, step_max);
            it.now_ns = clock_now;
        end
        it.verdict_in = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic run_random(input int count, input int rec_pct, input int step_max);
        for (int n = 0; n < count; n++)
            send_item(make_item(rec_pct, step_max));
    endtask

    initial
    begin
        logic [ttlrc_pkg::WORD_W-1:0] ones;
        ones       = '1;
        sb         = new();
        idle_on    = 1'b1;
        clock_now  = 64'd1000000;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        ttl_ns_we  <= 1'b0;
        ttl_ns     <= '0;
        op         <= ttlrc_pkg::OP_LOOKUP;
        addr_hi    <= '0;
        addr_lo    <= '0;
        is_v6      <= 1'b0;
        now_ns     <= '0;
        verdict_in <= 1'b0;
        for (int k = 0; k < KEY_POOL; k++)
        begin
            pool_v6[k] = 1'($urandom_range(0, 1));
            pool_hi[k] = pool_v6[k] ? {$urandom, $urandom} : '0;
            pool_lo[k] = pool_v6[k] ? {$urandom, $urandom} : {32'd0, $urandom};
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items under the lifetime that reset loads.
        send_fields(ttlrc_pkg::OP_LOOKUP, '0, '0, 1'b0, '0, 1'b0);
        send_fields(ttlrc_pkg::OP_RECORD, ones, 64'hFFFF_FFFF_C0A8_0001, 1'b0, 64'd1000, 1'b1);
        send_fields(ttlrc_pkg::OP_LOOKUP, '0, 64'h0000_0000_C0A8_0001, 1'b0, 64'd2000, 1'b0);
        send_fields(ttlrc_pkg::OP_LOOKUP, '0, 64'h0000_0000_C0A8_0001, 1'b1, 64'd2000, 1'b0);
        send_fields(ttlrc_pkg::OP_RECORD, ones, ones, 1'b1, 64'd5000, 1'b0);
        send_fields(ttlrc_pkg::OP_LOOKUP, ones, ones, 1'b1, 64'd6000, 1'b1);
        send_fields(ttlrc_pkg::OP_RECORD, ones, ones, 1'b1, 64'd7000, 1'b1);
        send_fields(ttlrc_pkg::OP_LOOKUP, ones, ones, 1'b1,
                    64'd7000 + ttlrc_pkg::TTL_RESET - 1, 1'b0);
        send_fields(ttlrc_pkg::OP_LOOKUP, ones, ones, 1'b1,
                    64'd7000 + ttlrc_pkg::TTL_RESET, 1'b0);
        send_fields(ttlrc_pkg::OP_LOOKUP, ones, ones, 1'b1, 64'd6999, 1'b0);
        send_fields(ttlrc_pkg::OP_RECORD, ones, '0, 1'b0, '0, 1'b1);
        send_fields(ttlrc_pkg::OP_LOOKUP, '0, '0, 1'b0, '0, 1'b0);
        send_fields(ttlrc_pkg::OP_RECORD, '0, '0, 1'b1, ones, 1'b1);
        send_fields(ttlrc_pkg::OP_LOOKUP, '0, '0, 1'b1, ones, 1'b0);
        send_fields(ttlrc_pkg::OP_LOOKUP, '0, '0, 1'b0, ones, 1'b0);
        send_fields(ttlrc_pkg::OP_RECORD, 64'h8000_0000_0000_0000, 64'd1, 1'b1, 64'd3, 1'b0);
        send_fields(ttlrc_pkg::OP_RECORD, '0, 64'h0000_0000_0A00_0001, 1'b0, 64'd10, 1'b1);
        send_fields(ttlrc_pkg::OP_LOOKUP, '0, '0, 1'b0, 64'd20, 1'b1);

        write_ttl(ones);
        run_random(250, 55, 5000);

        write_ttl('0);
        run_random(40, 40, 500);

        write_ttl(64'd1 * $urandom_range(2000, 20000));
        idle_on = 1'b0;
        run_random(120, 45, 1500);
        idle_on = 1'b1;
        run_random(130, 45, 1500);

        write_ttl({$urandom, $urandom});
        run_random(160, 45, 100000);

        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (ttlrc_pkg::ENTRIES + 10) @(posedge clk);

        $display("Covered %0d lookups (%0d expected hits) and %0d records under five lifetimes,",
                 sb.lookups, sb.hits, sb.records);
        $display("including zero and the largest lifetime; %0d mismatches found.", sb.errors);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
